/* sv/alternating_bit_sender_macros.svh */
// Assertion macros used by the checker file of the alternating-bit sender.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ALTERNATING_BIT_SENDER_MACROS_SVH
`define ALTERNATING_BIT_SENDER_MACROS_SVH

// same-cycle implication, quiet during reset
`define ABS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("abs assertion failed");

// next-cycle implication, quiet during reset
`define ABS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("abs assertion failed");

`endif

/* sv/abs_pkg.sv */
// Package of the alternating-bit sender: field widths, codes, command word and state types.
// No dependencies; imported by every module of the block.
package abs_pkg;

	localparam int BYTE_W = 8;
	localparam int ACK_W  = 10;
	localparam int CHK_W  = 16;
	localparam int HDR_W  = 32;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [ACK_W-1:0] ACK_RESET = 10'd999;

	// register index, taken from paddr above the byte offset
	localparam logic [APB_AW-3:0] REG_ACK_NUM = 1'b0;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = 2;

	typedef enum logic [1:0] {
		MODE_MSG   = 2'd0,
		MODE_ACK   = 2'd1,
		MODE_TIMER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_SEND   = 2'd0,
		CMD_RESEND = 2'd1,
		CMD_DROP   = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		logic             seq;
		logic [ACK_W-1:0] acknum;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE = 2'd0,
		B_COPY = 2'd1,
		B_EMIT = 2'd2
	} back_state_t;

endpackage

/* sv/alternating_bit_sender.sv */
// Top level of the alternating-bit sender: config register, front, command queue, back.
// Depends on abs_pkg, abs_front, abs_cmd_fifo and abs_back.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------------------
//   input   | in_valid / in_stall      | mode, data_byte, pkt_seqnum, pkt_acknum, pkt_checksum
//   output  | out_valid / out_stall    | kind, out_byte, out_last, out_seqnum, out_acknum,
//           |                          | out_checksum, start_timer
//   config  | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// The front takes one message, ack or timer word per cycle while in_stall is low.
// A packet leaves one byte per cycle while out_stall is low, PAYLOAD_BYTES bytes, from the in-flight buffer.
// A new send first copies its queue slot into that buffer over the single
// message-memory read port; the front holds in_stall until that copy ends.
// in_stall also rises when the four-entry command queue is full.
// Reset is asynchronous; no clearing pass, the block is ready the cycle after release.
module alternating_bit_sender import abs_pkg::*; #(
	parameter int PAYLOAD_BYTES = 20,
	parameter int QUEUE_MSGS    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              mode,
	input  logic [BYTE_W-1:0]       data_byte,
	input  logic signed [HDR_W-1:0] pkt_seqnum,
	input  logic signed [HDR_W-1:0] pkt_acknum,
	input  logic signed [HDR_W-1:0] pkt_checksum,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    kind,
	output logic [BYTE_W-1:0]       out_byte,
	output logic                    out_last,
	output logic                    out_seqnum,
	output logic [ACK_W-1:0]        out_acknum,
	output logic [CHK_W-1:0]        out_checksum,
	output logic                    start_timer,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_AW-1:0]       paddr,
	input  logic [APB_DW-1:0]       pwdata,
	output logic [APB_DW-1:0]       prdata,
	output logic                    pready
);

	localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1;
	localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	logic [ACK_W-1:0]  ack_reg_q;
	logic              reg_sel;

	logic              wr_en;
	logic [SW-1:0]     wr_slot;
	logic [IW-1:0]     wr_idx;
	logic [BYTE_W-1:0] wr_data;
	logic              cmd_push, cmdq_full, cmd_pop, cmd_valid, copy_done;
	cmd_t              push_cmd, pop_cmd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1:2] == REG_ACK_NUM);
	assign prdata  = reg_sel ? {{(APB_DW-ACK_W){1'b0}}, ack_reg_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_reg_q <= ACK_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			ack_reg_q <= pwdata[ACK_W-1:0];
		end
	end

	abs_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.QUEUE_MSGS   (QUEUE_MSGS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.data_byte   (data_byte),
		.pkt_seqnum  (pkt_seqnum),
		.pkt_acknum  (pkt_acknum),
		.pkt_checksum(pkt_checksum),
		.ack_reg     (ack_reg_q),
		.wr_en       (wr_en),
		.wr_slot     (wr_slot),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.cmd_push    (cmd_push),
		.cmd         (push_cmd),
		.cmdq_full   (cmdq_full),
		.copy_done   (copy_done)
	);

	abs_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(push_cmd),
		.full    (cmdq_full),
		.pop     (cmd_pop),
		.valid   (cmd_valid),
		.pop_cmd (pop_cmd)
	);

	abs_back #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.QUEUE_MSGS   (QUEUE_MSGS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_slot     (wr_slot),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.cmd_valid   (cmd_valid),
		.cmd         (pop_cmd),
		.cmd_pop     (cmd_pop),
		.copy_done   (copy_done),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.out_last    (out_last),
		.out_seqnum  (out_seqnum),
		.out_acknum  (out_acknum),
		.out_checksum(out_checksum),
		.start_timer (start_timer)
	);

endmodule

/* sv/abs_front.sv */
// Front of the alternating-bit sender: takes input words, fills the message queue,
// checks acknowledgments and issues send/resend/drop commands. Uses abs_pkg.
module abs_front import abs_pkg::*; #(
	parameter int PAYLOAD_BYTES = 20,
	parameter int QUEUE_MSGS    = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              mode,
	input  logic [BYTE_W-1:0]       data_byte,
	input  logic signed [HDR_W-1:0] pkt_seqnum,
	input  logic signed [HDR_W-1:0] pkt_acknum,
	input  logic signed [HDR_W-1:0] pkt_checksum,
	input  logic [ACK_W-1:0]        ack_reg,
	output logic                    wr_en,
	output logic [((QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1)-1:0]       wr_slot,
	output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] wr_idx,
	output logic [BYTE_W-1:0]       wr_data,
	output logic                    cmd_push,
	output cmd_t                    cmd,
	input  logic                    cmdq_full,
	input  logic                    copy_done
);

	localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1;
	localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CW = $clog2(QUEUE_MSGS + 1);

	logic              awaiting_q, awaiting_d;
	logic              send_bit_q, send_bit_d;
	logic [SW-1:0]     head_q, head_d, tail_q, tail_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     bc_q, bc_d, ac_q, ac_d;
	logic [HDR_W-1:0]  rx_sum_q, rx_sum_d;
	logic              drop_q, drop_d;
	logic              pending_q, pending_d;

	logic              accept;
	logic              drop_now;
	logic [HDR_W-1:0]  rx_next;
	logic [HDR_W-1:0]  ack_sum;
	logic              ack_ok;
	logic [SW-1:0]     head_inc, tail_inc;

	// a queued send holds the front until the back has copied its slot
	assign in_stall = cmdq_full || pending_q;
	assign accept   = in_valid && !in_stall;

	assign head_inc = (head_q == SW'(QUEUE_MSGS - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == SW'(QUEUE_MSGS - 1)) ? '0 : tail_q + 1'b1;

	assign drop_now = (bc_q == '0) ? (count_q >= CW'(QUEUE_MSGS)) : drop_q;
	assign rx_next  = rx_sum_q + {{(HDR_W-BYTE_W){1'b0}}, data_byte};
	assign ack_sum  = rx_next + $unsigned(pkt_seqnum) + $unsigned(pkt_acknum);
	assign ack_ok   = awaiting_q && (ack_sum == $unsigned(pkt_checksum))
		&& ($unsigned(pkt_acknum) == {{(HDR_W-1){1'b0}}, send_bit_q});

	assign wr_slot = tail_q;
	assign wr_idx  = bc_q;
	assign wr_data = data_byte;

	always_comb begin
		awaiting_d = awaiting_q;
		send_bit_d = send_bit_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		bc_d       = bc_q;
		ac_d       = ac_q;
		rx_sum_d   = rx_sum_q;
		drop_d     = drop_q;
		wr_en      = 1'b0;
		cmd_push   = 1'b0;
		cmd        = '{op: CMD_RESEND, seq: send_bit_q, acknum: ack_reg};
		if (accept) begin
			unique case (mode_t'(mode))
				MODE_MSG: begin
					drop_d = drop_now;
					wr_en  = !drop_now;
					if (bc_q == IW'(PAYLOAD_BYTES - 1)) begin
						bc_d = '0;
						if (drop_now) begin
							cmd_push = 1'b1;
							cmd.op   = CMD_DROP;
						end else begin
							tail_d = tail_inc;
							if (!awaiting_q) begin
								// goes straight out: head and tail both move
								cmd_push   = 1'b1;
								cmd.op     = CMD_SEND;
								head_d     = head_inc;
								awaiting_d = 1'b1;
							end else begin
								count_d = count_q + 1'b1;
							end
						end
					end else begin
						bc_d = bc_q + 1'b1;
					end
				end
				MODE_ACK: begin
					if (ac_q == IW'(PAYLOAD_BYTES - 1)) begin
						ac_d     = '0;
						rx_sum_d = '0;
						if (ack_ok) begin
							send_bit_d = !send_bit_q;
							if (count_q != '0) begin
								cmd_push = 1'b1;
								cmd.op   = CMD_SEND;
								cmd.seq  = !send_bit_q;
								head_d   = head_inc;
								count_d  = count_q - 1'b1;
							end else begin
								awaiting_d = 1'b0;
							end
						end
					end else begin
						ac_d     = ac_q + 1'b1;
						rx_sum_d = rx_next;
					end
				end
				MODE_TIMER: begin
					if (awaiting_q) begin
						cmd_push = 1'b1;
						cmd.op   = CMD_RESEND;
					end
				end
				default: begin
				end
			endcase
		end
		pending_d = pending_q;
		if (cmd_push && (cmd.op == CMD_SEND)) begin
			pending_d = 1'b1;
		end else if (copy_done) begin
			pending_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			send_bit_q <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			bc_q       <= '0;
			ac_q       <= '0;
			rx_sum_q   <= '0;
			drop_q     <= 1'b0;
			pending_q  <= 1'b0;
		end else begin
			awaiting_q <= awaiting_d;
			send_bit_q <= send_bit_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			bc_q       <= bc_d;
			ac_q       <= ac_d;
			rx_sum_q   <= rx_sum_d;
			drop_q     <= drop_d;
			pending_q  <= pending_d;
		end
	end

endmodule

/* sv/abs_cmd_fifo.sv */
// Short command queue between front and back of the alternating-bit sender.
// Uses abs_pkg for the command word and depth.
module abs_cmd_fifo import abs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_cmd
);

	cmd_t                 entry_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wp_q, rp_q;
	logic [CMDQ_AW:0]     cnt_q;

	assign full    = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign pop_cmd = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/abs_back.sv */
// Back of the alternating-bit sender: message memory, in-flight packet buffer,
// checksum pass and byte-serial packet output. Uses abs_pkg.
module abs_back import abs_pkg::*; #(
	parameter int PAYLOAD_BYTES = 20,
	parameter int QUEUE_MSGS    = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [((QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1)-1:0]       wr_slot,
	input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] wr_idx,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              copy_done,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              out_seqnum,
	output logic [ACK_W-1:0]  out_acknum,
	output logic [CHK_W-1:0]  out_checksum,
	output logic              start_timer
);

	localparam int SW = (QUEUE_MSGS > 1) ? $clog2(QUEUE_MSGS) : 1;
	localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int NW = $clog2(PAYLOAD_BYTES + 1);
	localparam int MSG_DEPTH = QUEUE_MSGS << IW;

	logic [BYTE_W-1:0] msg_mem [MSG_DEPTH];
	logic [BYTE_W-1:0] fl_mem  [PAYLOAD_BYTES];

	back_state_t       state_q, state_d;
	logic [NW-1:0]     cnt_q;
	logic [SW-1:0]     slot_q;
	logic              cp_vld_q;
	logic [IW-1:0]     cp_idx_q;
	logic [BYTE_W-1:0] msg_rd_q;
	logic [CHK_W-1:0]  sum_q;
	logic              fl_seq_q;
	logic [ACK_W-1:0]  fl_ack_q;
	logic [CHK_W-1:0]  fl_chk_q;

	logic              s1_vld_q, s1_kind_q, s1_last_q;
	logic [BYTE_W-1:0] s1_byte_q;

	logic              out_vld_q, out_kind_q, out_last_q, out_seq_q, out_timer_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [ACK_W-1:0]  out_ack_q;
	logic [CHK_W-1:0]  out_chk_q;

	logic out_free, s1_move, pop, issue, copy_rd, copy_fin, emit_fin;
	logic [CHK_W-1:0] sum_next;

	assign out_free = !out_vld_q || !out_stall;
	assign s1_move  = s1_vld_q && out_free;
	assign pop      = (state_q == B_IDLE) && cmd_valid && !s1_vld_q;
	assign issue    = (state_q == B_EMIT) && (!s1_vld_q || out_free);
	assign copy_rd  = (state_q == B_COPY) && (cnt_q < NW'(PAYLOAD_BYTES));
	assign copy_fin = (state_q == B_COPY) && (cnt_q == NW'(PAYLOAD_BYTES));
	assign emit_fin = issue && (cnt_q == NW'(PAYLOAD_BYTES - 1));
	assign sum_next = sum_q + {{(CHK_W-BYTE_W){1'b0}}, msg_rd_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (pop) begin
					unique case (cmd.op)
						CMD_SEND:   state_d = B_COPY;
						CMD_RESEND: state_d = B_EMIT;
						default:    state_d = B_IDLE;
					endcase
				end
			end
			B_COPY: begin
				if (copy_fin) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (emit_fin) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = pop;
		copy_done = copy_fin;
	end

	// message memory: front writes, copy pass reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			msg_mem[{wr_slot, wr_idx}] <= wr_data;
		end
		if (copy_rd) begin
			msg_rd_q <= msg_mem[{slot_q, cnt_q[IW-1:0]}];
		end
	end

	// in-flight buffer: copy pass writes, emit reads
	always_ff @(posedge clk) begin
		if (cp_vld_q) begin
			fl_mem[cp_idx_q] <= msg_rd_q;
		end
		if (issue) begin
			s1_byte_q <= fl_mem[cnt_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		cp_idx_q <= cnt_q[IW-1:0];
		if (pop && (cmd.op == CMD_SEND)) begin
			fl_seq_q <= cmd.seq;
			fl_ack_q <= cmd.acknum;
			sum_q    <= {{(CHK_W-1){1'b0}}, cmd.seq} + {{(CHK_W-ACK_W){1'b0}}, cmd.acknum};
		end else if (cp_vld_q) begin
			sum_q <= sum_next;
		end
		if (copy_fin) begin
			fl_chk_q <= sum_next;
		end
		if (s1_move) begin
			out_kind_q  <= s1_kind_q;
			out_byte_q  <= s1_kind_q ? '0 : s1_byte_q;
			out_last_q  <= s1_last_q;
			out_seq_q   <= s1_kind_q ? 1'b0 : fl_seq_q;
			out_ack_q   <= s1_kind_q ? '0 : fl_ack_q;
			out_chk_q   <= s1_kind_q ? '0 : fl_chk_q;
			out_timer_q <= !s1_kind_q && s1_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			cnt_q     <= '0;
			slot_q    <= '0;
			cp_vld_q  <= 1'b0;
			s1_vld_q  <= 1'b0;
			s1_kind_q <= 1'b0;
			s1_last_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cp_vld_q <= copy_rd;
			if (pop || copy_fin) begin
				cnt_q <= '0;
			end else if (copy_rd || issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (copy_fin) begin
				slot_q <= (slot_q == SW'(QUEUE_MSGS - 1)) ? '0 : slot_q + 1'b1;
			end
			if (issue) begin
				s1_vld_q  <= 1'b1;
				s1_kind_q <= 1'b0;
				s1_last_q <= (cnt_q == NW'(PAYLOAD_BYTES - 1));
			end else if (pop && (cmd.op == CMD_DROP)) begin
				s1_vld_q  <= 1'b1;
				s1_kind_q <= 1'b1;
				s1_last_q <= 1'b1;
			end else if (s1_move) begin
				s1_vld_q <= 1'b0;
			end
			if (out_free) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign kind         = out_kind_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;
	assign out_seqnum   = out_seq_q;
	assign out_acknum   = out_ack_q;
	assign out_checksum = out_chk_q;
	assign start_timer  = out_timer_q;

endmodule

/* sv/abs_checker.sv */
// Port-level checks on the output word stream of the alternating-bit sender.
// Uses alternating_bit_sender_macros.svh; bound to the top level below.
`include "alternating_bit_sender_macros.svh"

module abs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [7:0]  out_byte,
	input logic        out_last,
	input logic        out_seqnum,
	input logic [9:0]  out_acknum,
	input logic [15:0] out_checksum,
	input logic        start_timer
);

	// a stalled word keeps its byte, checksum, sequence bit and marks
	`ABS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_checksum) && $stable(out_last) && $stable(kind) && $stable(out_seqnum))

	// timer request only on the closing byte of a packet
	`ABS_ASSERT_NOW(a_timer_on_last, out_valid && !kind, out_last == start_timer)

	// drop notice is a single word with every header field clear
	`ABS_ASSERT_NOW(a_drop_clean, out_valid && kind, out_last && !start_timer && (out_byte == 8'd0) && (out_checksum == 16'd0) && !out_seqnum && (out_acknum == 10'd0))

endmodule

bind alternating_bit_sender abs_checker u_abs_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the alternating-bit sender: drives message, ack and timer
// words, writes the ack-number register over APB and checks every output word in order.
// Depends on abs_pkg and alternating_bit_sender.
module testbench import abs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAYLOAD_BYTES = 20;
	localparam int QUEUE_MSGS    = 8;
	localparam int DRAIN_CYCLES  = 100;
	localparam int PHASE_WORDS   = 10;
	localparam int HOLD_CYCLES   = 800;
	localparam int MAX_GAP       = 40;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	localparam logic [1:0]        MODE_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] ACK_ADDR    = {REG_ACK_NUM, 2'b00};

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;
	typedef enum {ACK_GOOD, ACK_WRAP, ACK_BAD_SUM, ACK_BAD_NUM} ack_flaw_t;

	typedef struct {
		logic              kind;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              seq;
		logic [ACK_W-1:0]  acknum;
		logic [CHK_W-1:0]  checksum;
		logic              timer;
	} tx_word_t;

	class packet_scoreboard;
		tx_word_t         expected_words[$];
		int               errors;
		logic [ACK_W-1:0] ack_reg;
		bit               awaiting;
		bit               send_bit;
		logic [7:0]       msg_store[QUEUE_MSGS*PAYLOAD_BYTES];
		int               q_head, q_tail, q_count;
		int               msg_count, ack_count;
		logic [31:0]      rx_sum;
		bit               drop_latch;
		logic [7:0]       inflight[PAYLOAD_BYTES];
		logic [CHK_W-1:0] inflight_sum;
		logic [ACK_W-1:0] inflight_ack;

		function new();
			ack_reg = ACK_RESET;
			rx_sum = '0;
			inflight_sum = '0;
			inflight_ack = '0;
			foreach (msg_store[i]) msg_store[i] = '0;
			foreach (inflight[i]) inflight[i] = '0;
		endfunction

		function tx_word_t word_of(logic k, logic [7:0] d, logic l, logic s,
				logic [ACK_W-1:0] a, logic [CHK_W-1:0] c, logic t);
			tx_word_t w;
			w.kind = k;
			w.data = d;
			w.last = l;
			w.seq = s;
			w.acknum = a;
			w.checksum = c;
			w.timer = t;
			return w;
		endfunction

		function void emit_packet();
			bit l;
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				l = (i == PAYLOAD_BYTES - 1);
				expected_words.push_back(word_of(1'b0, inflight[i], l, send_bit,
					inflight_ack, inflight_sum, l));
			end
		endfunction

		// head of the queue becomes the packet in flight
		function void send_next();
			int sum;
			sum = 0;
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				inflight[i] = msg_store[q_head*PAYLOAD_BYTES + i];
				sum += inflight[i];
			end
			inflight_ack = ack_reg;
			sum += send_bit + inflight_ack;
			inflight_sum = sum[CHK_W-1:0];
			q_head = (q_head + 1) % QUEUE_MSGS;
			q_count--;
			awaiting = 1'b1;
			emit_packet();
		endfunction

		function void take_input_word(logic [1:0] m, logic [7:0] d,
				logic [31:0] s, logic [31:0] a, logic [31:0] c);
			logic [31:0] total;
			case (m)
				MODE_MSG: begin
					// drop decision is made on the first byte and sticks
					if (msg_count == 0) drop_latch = (q_count >= QUEUE_MSGS);
					if (!drop_latch) msg_store[q_tail*PAYLOAD_BYTES + msg_count] = d;
					msg_count++;
					if (msg_count < PAYLOAD_BYTES) return;
					msg_count = 0;
					if (drop_latch) begin
						expected_words.push_back(word_of(1'b1, '0, 1'b1, 1'b0, '0, '0, 1'b0));
						return;
					end
					q_tail = (q_tail + 1) % QUEUE_MSGS;
					q_count++;
					if (!awaiting) send_next();
				end
				MODE_ACK: begin
					rx_sum += d;
					ack_count++;
					if (ack_count < PAYLOAD_BYTES) return;
					total = rx_sum + s + a;
					ack_count = 0;
					rx_sum = '0;
					if (!awaiting || total != c || a != {31'b0, send_bit}) return;
					send_bit = !send_bit;
					awaiting = 1'b0;
					if (q_count > 0) send_next();
				end
				MODE_TIMER: begin
					if (awaiting) emit_packet();
				end
				default: ;
			endcase
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
			errors++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) report({"output word field ", name}, got, want);
		endtask

		task check_output_word(tx_word_t got);
			tx_word_t want;
			if (expected_words.size() == 0) begin
				report("output word with nothing expected", 32'(got.data), 32'd0);
				return;
			end
			want = expected_words.pop_front();
			check_field("kind", 32'(got.kind), 32'(want.kind));
			check_field("out_byte", 32'(got.data), 32'(want.data));
			check_field("out_last", 32'(got.last), 32'(want.last));
			check_field("out_seqnum", 32'(got.seq), 32'(want.seq));
			check_field("out_acknum", 32'(got.acknum), 32'(want.acknum));
			check_field("out_checksum", 32'(got.checksum), 32'(want.checksum));
			check_field("start_timer", 32'(got.timer), 32'(want.timer));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              mode;
	logic [BYTE_W-1:0]       data_byte;
	logic signed [HDR_W-1:0] pkt_seqnum;
	logic signed [HDR_W-1:0] pkt_acknum;
	logic signed [HDR_W-1:0] pkt_checksum;
	logic                    out_valid;
	logic                    out_stall;
	logic                    kind;
	logic [BYTE_W-1:0]       out_byte;
	logic                    out_last;
	logic                    out_seqnum;
	logic [ACK_W-1:0]        out_acknum;
	logic [CHK_W-1:0]        out_checksum;
	logic                    start_timer;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [APB_DW-1:0]       pwdata;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;

	packet_scoreboard sb;
	int               send_idle_pct;
	int               stall_pct;
	bit               hold_req;
	int               hold_left;
	int               words_sent;
	int unsigned      cycles;

	alternating_bit_sender #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.QUEUE_MSGS(QUEUE_MSGS)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		tx_word_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.kind = kind;
			seen.data = out_byte;
			seen.last = out_last;
			seen.seq = out_seqnum;
			seen.acknum = out_acknum;
			seen.checksum = out_checksum;
			seen.timer = start_timer;
			sb.check_output_word(seen);
		end
	end

	// called at a rising edge; returns at a rising edge
	task automatic drive_word(input logic [1:0] m, input logic [7:0] d,
			input logic [31:0] s, input logic [31:0] a, input logic [31:0] c);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= d;
		pkt_seqnum <= s;
		pkt_acknum <= a;
		pkt_checksum <= c;
		do @(posedge clk); while (in_stall);
		sb.take_input_word(m, d, s, a, c);
		if (m != MODE_UNUSED) words_sent++;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_input();
		in_valid <= 1'b0;
	endtask

	task automatic send_message(input fill_t fill);
		logic [7:0] d;
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			d = (fill == FILL_ONES) ? 8'hFF : (fill == FILL_ZEROS) ? 8'h00 : 8'($urandom);
			drive_word(MODE_MSG, d, $urandom, $urandom, $urandom);
		end
	endtask

	// header only matters on the final byte; it is built from the state at that point
	task automatic ack_byte(input int idx, input ack_flaw_t flaw);
		logic [7:0]  d;
		logic [31:0] s, a, c;
		d = 8'($urandom);
		s = $urandom;
		a = $urandom;
		c = $urandom;
		if (idx == PAYLOAD_BYTES - 1) begin
			if (flaw == ACK_WRAP) s = 32'hFFFF_FFFF;
			if (flaw == ACK_BAD_NUM) begin
				if ($urandom_range(1)) a = {31'b0, !sb.send_bit};
				else if (a == {31'b0, sb.send_bit}) a ^= 32'h2;
			end else begin
				a = {31'b0, sb.send_bit};
			end
			c = sb.rx_sum + d + s + a;
			if (flaw == ACK_BAD_SUM) c ^= 32'h1 << $urandom_range(31);
		end
		drive_word(MODE_ACK, d, s, a, c);
	endtask

	task automatic send_ack(input ack_flaw_t flaw);
		for (int i = 0; i < PAYLOAD_BYTES; i++) ack_byte(i, flaw);
	endtask

	// message and ack bytes interleaved; the two byte counters are independent
	task automatic send_mixed();
		int msg_left, ack_left;
		msg_left = PAYLOAD_BYTES;
		ack_left = PAYLOAD_BYTES;
		while (msg_left + ack_left > 0) begin
			if (ack_left == 0 || (msg_left > 0 && $urandom_range(1))) begin
				drive_word(MODE_MSG, 8'($urandom), $urandom, $urandom, $urandom);
				msg_left--;
			end else begin
				ack_byte(PAYLOAD_BYTES - ack_left, ACK_GOOD);
				ack_left--;
			end
		end
	endtask

	task automatic random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 4) send_message(FILL_ONES);
		else if (pick < 8) send_message(FILL_ZEROS);
		else if (pick < 40) send_message(FILL_RANDOM);
		else if (pick < 62) send_ack(ACK_GOOD);
		else if (pick < 67) send_ack(ACK_BAD_SUM);
		else if (pick < 72) send_ack(ACK_BAD_NUM);
		else if (pick < 82) drive_word(MODE_TIMER, 8'($urandom), $urandom, $urandom, $urandom);
		else if (pick < 87) drive_word(MODE_UNUSED, 8'($urandom), $urandom, $urandom, $urandom);
		else send_mixed();
	endtask

	task automatic wait_for_drain();
		stop_input();
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_ack_reg(input logic [ACK_W-1:0] value);
		logic [APB_DW-1:0] w;
		w = $urandom;
		w[ACK_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ACK_ADDR;
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.ack_reg = value;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_ack_reg();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ACK_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(APB_DW-ACK_W){1'b0}}, sb.ack_reg})
			sb.report("ack register readback", prdata, 32'(sb.ack_reg));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic random_phase(input int idle, input int stall, input logic [ACK_W-1:0] reg_val);
		int start;
		wait_for_drain();
		write_ack_reg(reg_val);
		read_ack_reg();
		send_idle_pct = idle;
		stall_pct = stall;
		start = words_sent;
		while (words_sent - start < PHASE_WORDS) random_sequence();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_MSG;
		data_byte = '0;
		pkt_seqnum = '0;
		pkt_acknum = '0;
		pkt_checksum = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_ack_reg();

		// directed: ignored words while idle
		drive_word(MODE_TIMER, 8'h00, 32'h0, 32'h0, 32'h0);
		drive_word(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// back-pressure: receiver holds off while the first packet and a run of
		// timer resends fill the command queue, so the input stalls
		hold_req = 1'b1;
		send_message(FILL_ONES);
		repeat (CMDQ_DEPTH + 2)
			drive_word(MODE_TIMER, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		wait_for_drain();

		// resend must keep the ack number the packet was built with
		write_ack_reg(10'd1023);
		read_ack_reg();
		drive_word(MODE_TIMER, 8'h55, 32'h0, 32'h0, 32'h0);
		send_ack(ACK_WRAP);

		random_phase(0, 0, 10'd0);
		random_phase(88, 0, 10'd1023);
		random_phase(0, 88, ACK_W'($urandom));
		random_phase(24, 24, ACK_W'($urandom));

		wait_for_drain();
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
